// File: hw/rtl/vtkp_pkg.sv
`default_nettype none

package vtkp_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [3:0] REG_JOY_A     = 4'd0;
  localparam logic [3:0] REG_KEY_A     = 4'd1;
  localparam logic [3:0] REG_KEY_B     = 4'd2;
  localparam logic [3:0] REG_KEY_DIR   = 4'd3;
  localparam logic [3:0] REG_T1C_LO    = 4'd4;
  localparam logic [3:0] REG_T1C_HI    = 4'd5;
  localparam logic [3:0] REG_T1L_LO    = 4'd6;
  localparam logic [3:0] REG_T1L_HI    = 4'd7;
  localparam logic [3:0] REG_T2C_LO    = 4'd8;
  localparam logic [3:0] REG_T2C_HI    = 4'd9;
  localparam logic [3:0] REG_T2L_LO    = 4'd10;
  localparam logic [3:0] REG_T2L_HI    = 4'd11;
  localparam logic [3:0] REG_T2_ARMED  = 4'd12;
  localparam logic [3:0] REG_FLAGS     = 4'd13;
  localparam logic [3:0] REG_ENABLE    = 4'd14;
  localparam logic [3:0] REG_AUX       = 4'd15;

  localparam logic [7:0] JOY_A_RESET    = 8'hFF;
  localparam logic [7:0] JOY_SET_MASK   = 8'h3C;
  localparam logic [7:0] COL_SHIFT      = 8'hF7;
  localparam logic [7:0] COL_CBM        = 8'hDF;
  localparam logic [7:0] SHIFT_ROW_MASK = 8'hFD;
  localparam logic [7:0] CBM_ROW_MASK   = 8'hFE;
  localparam logic [7:0] IRQ_MASK       = 8'h7F;
  localparam logic [7:0] FLAG_T1        = 8'h40;
  localparam logic [7:0] FLAG_T2        = 8'h20;
  localparam logic [7:0] ROW_NONE       = 8'hFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  reg_index;
    logic [7:0]  write_data;
    logic [15:0] key_code;
    logic        shift_down;
    logic        commodore_down;
    logic [4:0]  joystick_bits;
    logic        cpu_takes_irq;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/via_timer_keyboard_port_model.sv
// timer and keyboard/joystick port model of a pair of interface adapters
// in_*  : one item per transfer: tick, raw register write or raw register read
// out_* : exactly one result per input item, in order
// an accepted item sits in the input register until the result register
// is free or being taken; then the single-pass update logic applies it to
// the 16-byte register map and loads the result register
// one item per clock is sustained while out_ready is high; the rate is set
// by the single update stage, which reads the state written by the item before it
// when out_ready is low the result register holds, the input register
// fills, then in_ready drops until the result is taken
// a synchronous reset (rst_n low) empties both registers and sets the
// register map to zero, joystick port byte to 0xff
// read_data is zero except on a read; irq_request is set only by a tick
`default_nettype none

module via_timer_keyboard_port_model (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  vtkp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output vtkp_pkg::out_item_t out_data
);

  vtkp_pkg::in_item_t  in_q_r;
  logic                in_valid_r;
  logic                out_valid_r;
  vtkp_pkg::out_item_t out_data_r, out_data_nxt;
  logic                fire;

  logic [7:0]  joy_a_r, joy_a_nxt;
  logic [7:0]  key_a_r, key_a_nxt;
  logic [7:0]  key_b_r, key_b_nxt;
  logic [7:0]  key_dir_r, key_dir_nxt;
  logic [15:0] t1c_r, t1c_nxt;
  logic [15:0] t1l_r, t1l_nxt;
  logic [15:0] t2c_r, t2c_nxt;
  logic [15:0] t2l_r, t2l_nxt;
  logic [7:0]  t2_armed_r, t2_armed_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  enable_r, enable_nxt;
  logic [7:0]  aux_r, aux_nxt;

  logic [15:0] t1_dec;
  logic [15:0] t2_dec;
  logic [7:0]  flags_t;
  logic        irq;
  logic [7:0]  joy_tick;
  logic [7:0]  key_b_tick;
  logic [7:0]  col, row;
  logic        key_none;
  logic [7:0]  reply;
  logic [7:0]  rd_byte;

  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register map read
  always_comb begin
    unique case (in_q_r.reg_index)
      vtkp_pkg::REG_JOY_A:    rd_byte = joy_a_r;
      vtkp_pkg::REG_KEY_A:    rd_byte = key_a_r;
      vtkp_pkg::REG_KEY_B:    rd_byte = key_b_r;
      vtkp_pkg::REG_KEY_DIR:  rd_byte = key_dir_r;
      vtkp_pkg::REG_T1C_LO:   rd_byte = t1c_r[7:0];
      vtkp_pkg::REG_T1C_HI:   rd_byte = t1c_r[15:8];
      vtkp_pkg::REG_T1L_LO:   rd_byte = t1l_r[7:0];
      vtkp_pkg::REG_T1L_HI:   rd_byte = t1l_r[15:8];
      vtkp_pkg::REG_T2C_LO:   rd_byte = t2c_r[7:0];
      vtkp_pkg::REG_T2C_HI:   rd_byte = t2c_r[15:8];
      vtkp_pkg::REG_T2L_LO:   rd_byte = t2l_r[7:0];
      vtkp_pkg::REG_T2L_HI:   rd_byte = t2l_r[15:8];
      vtkp_pkg::REG_T2_ARMED: rd_byte = t2_armed_r;
      vtkp_pkg::REG_FLAGS:    rd_byte = flags_r;
      vtkp_pkg::REG_ENABLE:   rd_byte = enable_r;
      vtkp_pkg::REG_AUX:      rd_byte = aux_r;
      default:                rd_byte = '0;
    endcase
  end

  // tick datapath
  always_comb begin
    t1_dec = (t1c_r != '0) ? t1c_r - 16'd1 : t1c_r;
    t2_dec = (t2c_r != '0) ? t2c_r - 16'd1 : t2c_r;

    flags_t = flags_r;
    if (t1_dec == '0) begin
      flags_t = flags_t | vtkp_pkg::FLAG_T1;
    end
    if (t2_armed_r != '0 && t2_dec == '0) begin
      flags_t = flags_t | vtkp_pkg::FLAG_T2;
    end
    irq = |(flags_t & enable_r & vtkp_pkg::IRQ_MASK);

    joy_tick = joy_a_r | vtkp_pkg::JOY_SET_MASK;
    if (in_q_r.joystick_bits[0]) joy_tick[5] = 1'b0;
    if (in_q_r.joystick_bits[1]) joy_tick[2] = 1'b0;
    if (in_q_r.joystick_bits[2]) joy_tick[3] = 1'b0;
    if (in_q_r.joystick_bits[3]) joy_tick[4] = 1'b0;

    key_b_tick = key_b_r;
    if (!key_dir_r[7]) key_b_tick[7] = 1'b1;
    if (in_q_r.joystick_bits[4]) key_b_tick[7] = 1'b0;

    col      = in_q_r.key_code[15:8];
    row      = in_q_r.key_code[7:0];
    key_none = (in_q_r.key_code == '0);
    if (key_b_tick == '0) begin
      reply = key_none ? vtkp_pkg::ROW_NONE : row;
    end else begin
      reply = (key_b_tick == col && row != '0) ? row : vtkp_pkg::ROW_NONE;
    end
    if (key_b_tick == vtkp_pkg::COL_SHIFT && in_q_r.shift_down) begin
      reply = vtkp_pkg::SHIFT_ROW_MASK &
              ((!key_none && col == vtkp_pkg::COL_SHIFT) ? row : vtkp_pkg::ROW_NONE);
    end else if (key_b_tick == vtkp_pkg::COL_CBM && in_q_r.commodore_down) begin
      reply = vtkp_pkg::CBM_ROW_MASK &
              ((!key_none && col == vtkp_pkg::COL_CBM) ? row : vtkp_pkg::ROW_NONE);
    end
  end

  // next state and result
  always_comb begin
    joy_a_nxt    = joy_a_r;
    key_a_nxt    = key_a_r;
    key_b_nxt    = key_b_r;
    key_dir_nxt  = key_dir_r;
    t1c_nxt      = t1c_r;
    t1l_nxt      = t1l_r;
    t2c_nxt      = t2c_r;
    t2l_nxt      = t2l_r;
    t2_armed_nxt = t2_armed_r;
    flags_nxt    = flags_r;
    enable_nxt   = enable_r;
    aux_nxt      = aux_r;
    out_data_nxt = '0;

    case (in_q_r.opcode)
      vtkp_pkg::OP_TICK: begin
        t1c_nxt = t1_dec;
        if (t2_armed_r != '0) begin
          if (t2_dec == '0) begin
            t2c_nxt      = t2l_r;
            t2_armed_nxt = '0;
          end else begin
            t2c_nxt = t2_dec;
          end
        end
        flags_nxt = flags_t;
        if (irq && in_q_r.cpu_takes_irq) begin
          if ((flags_t & vtkp_pkg::FLAG_T1) != '0 &&
              (aux_r & vtkp_pkg::FLAG_T1) != '0) begin
            t1c_nxt = t1l_r;
          end
          flags_nxt = flags_t & ~(vtkp_pkg::FLAG_T1 | vtkp_pkg::FLAG_T2);
        end
        joy_a_nxt = joy_tick;
        key_b_nxt = key_b_tick;
        key_a_nxt = reply;
        out_data_nxt.irq_request = irq;
      end
      vtkp_pkg::OP_WRITE: begin
        unique case (in_q_r.reg_index)
          vtkp_pkg::REG_JOY_A:    joy_a_nxt        = in_q_r.write_data;
          vtkp_pkg::REG_KEY_A:    key_a_nxt        = in_q_r.write_data;
          vtkp_pkg::REG_KEY_B:    key_b_nxt        = in_q_r.write_data;
          vtkp_pkg::REG_KEY_DIR:  key_dir_nxt      = in_q_r.write_data;
          vtkp_pkg::REG_T1C_LO:   t1c_nxt[7:0]     = in_q_r.write_data;
          vtkp_pkg::REG_T1C_HI:   t1c_nxt[15:8]    = in_q_r.write_data;
          vtkp_pkg::REG_T1L_LO:   t1l_nxt[7:0]     = in_q_r.write_data;
          vtkp_pkg::REG_T1L_HI:   t1l_nxt[15:8]    = in_q_r.write_data;
          vtkp_pkg::REG_T2C_LO:   t2c_nxt[7:0]     = in_q_r.write_data;
          vtkp_pkg::REG_T2C_HI:   t2c_nxt[15:8]    = in_q_r.write_data;
          vtkp_pkg::REG_T2L_LO:   t2l_nxt[7:0]     = in_q_r.write_data;
          vtkp_pkg::REG_T2L_HI:   t2l_nxt[15:8]    = in_q_r.write_data;
          vtkp_pkg::REG_T2_ARMED: t2_armed_nxt     = in_q_r.write_data;
          vtkp_pkg::REG_FLAGS:    flags_nxt        = in_q_r.write_data;
          vtkp_pkg::REG_ENABLE:   enable_nxt       = in_q_r.write_data;
          vtkp_pkg::REG_AUX:      aux_nxt          = in_q_r.write_data;
          default:                aux_nxt          = aux_r;
        endcase
      end
      vtkp_pkg::OP_READ: begin
        out_data_nxt.read_data = rd_byte;
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      joy_a_r     <= vtkp_pkg::JOY_A_RESET;
      key_a_r     <= '0;
      key_b_r     <= '0;
      key_dir_r   <= '0;
      t1c_r       <= '0;
      t1l_r       <= '0;
      t2c_r       <= '0;
      t2l_r       <= '0;
      t2_armed_r  <= '0;
      flags_r     <= '0;
      enable_r    <= '0;
      aux_r       <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        joy_a_r     <= joy_a_nxt;
        key_a_r     <= key_a_nxt;
        key_b_r     <= key_b_nxt;
        key_dir_r   <= key_dir_nxt;
        t1c_r       <= t1c_nxt;
        t1l_r       <= t1l_nxt;
        t2c_r       <= t2c_nxt;
        t2l_r       <= t2l_nxt;
        t2_armed_r  <= t2_armed_nxt;
        flags_r     <= flags_nxt;
        enable_r    <= enable_nxt;
        aux_r       <= aux_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_q_r.opcode != vtkp_pkg::OP_TICK |=> !out_data_r.irq_request)
    else $error("irq request on a non-tick item");

  a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_q_r.opcode != vtkp_pkg::OP_READ |=> out_data_r.read_data == '0)
    else $error("read data on a non-read item");

  a_t2_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_q_r.opcode == vtkp_pkg::OP_TICK && t2_armed_r != '0 && t2c_r <= 16'd1
    |=> t2_armed_r == '0)
    else $error("timer two still armed after expiry");

  a_joy_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_q_r.opcode == vtkp_pkg::OP_TICK
    |=> joy_a_r[7:6] == $past(joy_a_r[7:6]) && joy_a_r[1:0] == $past(joy_a_r[1:0]))
    else $error("tick changed joystick port bits outside the merge mask");
`endif

endmodule

`default_nettype wire

// File: bench/vtkp_tb_pkg.sv
package vtkp_tb_pkg;

  import vtkp_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [7:0] AUX_T1_RELOAD = 8'h40;
  localparam logic [7:0] FIRE_MASK     = 8'h20;
  localparam logic [7:0] UP_MASK       = 8'h04;
  localparam logic [7:0] DOWN_MASK     = 8'h08;
  localparam logic [7:0] LEFT_MASK     = 8'h10;

  class port_map_checker;
    logic [7:0]  regmap [16];
    out_item_t   pending_results [$];
    int unsigned mismatches;

    function new();
      foreach (regmap[i]) regmap[i] = 8'h00;
      regmap[REG_JOY_A] = JOY_A_RESET;
      mismatches = 0;
    endfunction

    function out_item_t run_item(in_item_t item);
      out_item_t   res;
      logic [7:0]  flags;
      logic [7:0]  joy_a;
      logic [7:0]  key_b;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [7:0]  reply;
      logic [15:0] t1;
      logic [15:0] t2;
      res = '0;
      case (item.opcode)
        OP_WRITE: regmap[item.reg_index] = item.write_data;
        OP_READ: res.read_data = regmap[item.reg_index];
        OP_TICK: begin
          flags = regmap[REG_FLAGS];
          t1 = {regmap[REG_T1C_HI], regmap[REG_T1C_LO]};
          t2 = {regmap[REG_T2C_HI], regmap[REG_T2C_LO]};
          if (t1 != 16'd0) begin
            t1 = t1 - 16'd1;
            {regmap[REG_T1C_HI], regmap[REG_T1C_LO]} = t1;
          end
          if (t1 == 16'd0) flags = flags | FLAG_T1;
          if (regmap[REG_T2_ARMED] != 8'h00) begin
            if (t2 != 16'd0) begin
              t2 = t2 - 16'd1;
              {regmap[REG_T2C_HI], regmap[REG_T2C_LO]} = t2;
            end
            if (t2 == 16'd0) begin
              regmap[REG_T2C_LO] = regmap[REG_T2L_LO];
              regmap[REG_T2C_HI] = regmap[REG_T2L_HI];
              regmap[REG_T2_ARMED] = 8'h00;
              flags = flags | FLAG_T2;
            end
          end
          if ((flags & regmap[REG_ENABLE] & IRQ_MASK) != 8'h00) begin
            res.irq_request = 1'b1;
            if (item.cpu_takes_irq) begin
              if ((flags & FLAG_T1) != 8'h00) begin
                if ((regmap[REG_AUX] & AUX_T1_RELOAD) != 8'h00) begin
                  regmap[REG_T1C_LO] = regmap[REG_T1L_LO];
                  regmap[REG_T1C_HI] = regmap[REG_T1L_HI];
                end
                flags = flags & ~FLAG_T1;
              end
              flags = flags & ~FLAG_T2;
            end
          end
          regmap[REG_FLAGS] = flags;

          joy_a = regmap[REG_JOY_A] | JOY_SET_MASK;
          if (item.joystick_bits[0]) joy_a = joy_a & ~FIRE_MASK;
          if (item.joystick_bits[1]) joy_a = joy_a & ~UP_MASK;
          if (item.joystick_bits[2]) joy_a = joy_a & ~DOWN_MASK;
          if (item.joystick_bits[3]) joy_a = joy_a & ~LEFT_MASK;
          regmap[REG_JOY_A] = joy_a;

          key_b = regmap[REG_KEY_B];
          if (!regmap[REG_KEY_DIR][7]) key_b[7] = 1'b1;
          if (item.joystick_bits[4]) key_b[7] = 1'b0;
          regmap[REG_KEY_B] = key_b;

          col = item.key_code[15:8];
          row = item.key_code[7:0];
          if (key_b == 8'h00)
            reply = (item.key_code == 16'h0000) ? ROW_NONE : row;
          else
            reply = (key_b == col) ? ((row == 8'h00) ? ROW_NONE : row) : ROW_NONE;
          if (key_b == COL_SHIFT && item.shift_down)
            reply = SHIFT_ROW_MASK & ((item.key_code == 16'h0000) ? ROW_NONE :
                                      ((col == COL_SHIFT) ? row : ROW_NONE));
          else if (key_b == COL_CBM && item.commodore_down)
            reply = CBM_ROW_MASK & ((item.key_code == 16'h0000) ? ROW_NONE :
                                    ((col == COL_CBM) ? row : ROW_NONE));
          regmap[REG_KEY_A] = reply;
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_item(in_item_t item);
      pending_results.push_back(run_item(item));
    endfunction

    function void note_fault(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected read_data %02h irq_request %0b, got read_data %02h irq_request %0b",
                 what, want.read_data, want.irq_request, got.read_data, got.irq_request);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        note_fault("unexpected result", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data || got.irq_request !== want.irq_request)
        note_fault("result mismatch", want, got);
    endfunction
  endclass

endpackage

// File: bench/via_timer_keyboard_port_model_tb.sv
module via_timer_keyboard_port_model_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import vtkp_pkg::*;
  import vtkp_tb_pkg::*;

  localparam int unsigned RANDOM_OPS  = 1150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_data;

  port_map_checker book = new();
  int unsigned     cycle_count = 0;
  int unsigned     counted_ops = 0;
  int unsigned     results_seen = 0;
  bit              sender_quiet = 1'b0;
  bit              receiver_quiet = 1'b0;

  via_timer_keyboard_port_model DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("via_timer_keyboard_port_model verification failed");
      $finish;
    end
  end

  function automatic in_item_t reg_item(logic [1:0] op, logic [3:0] idx, logic [7:0] data);
    in_item_t item;
    item = '0;
    item.opcode = op;
    item.reg_index = idx;
    item.write_data = data;
    return item;
  endfunction

  function automatic in_item_t tick_item(logic [15:0] key, logic shift, logic cbm,
                                         logic [4:0] joy, logic takes);
    in_item_t item;
    item = '0;
    item.opcode = OP_TICK;
    item.key_code = key;
    item.shift_down = shift;
    item.commodore_down = cbm;
    item.joystick_bits = joy;
    item.cpu_takes_irq = takes;
    return item;
  endfunction

  function automatic in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  // key column aimed, on half the ticks, at the column port as the tick will leave it
  function automatic in_item_t random_tick();
    in_item_t   item;
    logic [7:0] col;
    item = noise_item();
    item.opcode = OP_TICK;
    item.joystick_bits[4] = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: item.key_code = 16'h0000;
      1: ;
      default: begin
        col = book.regmap[REG_KEY_B];
        if (!book.regmap[REG_KEY_DIR][7]) col[7] = 1'b1;
        if (item.joystick_bits[4]) col[7] = 1'b0;
        item.key_code = {col, ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom)};
      end
    endcase
    return item;
  endfunction

  // small timer values so that counts run out within a burst
  function automatic in_item_t setup_write();
    logic [3:0] idx;
    logic [7:0] data;
    idx = 4'($urandom_range(0, 15));
    data = 8'($urandom);
    case (idx)
      REG_T1C_HI, REG_T1L_HI, REG_T2C_HI, REG_T2L_HI: begin
        if ($urandom_range(0, 3) != 0) data = 8'h00;
      end
      REG_T1C_LO, REG_T1L_LO, REG_T2C_LO, REG_T2L_LO: begin
        if ($urandom_range(0, 4) != 0) data = 8'($urandom_range(0, 12));
      end
      REG_KEY_B: begin
        case ($urandom_range(0, 3))
          0: data = COL_SHIFT;
          1: data = COL_CBM;
          2: data = 8'h00;
          default: ;
        endcase
      end
      default: ;
    endcase
    return reg_item(OP_WRITE, idx, data);
  endfunction

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    book.note_item(item);
    if (item.opcode != OP_UNUSED) counted_ops++;
  endtask

  initial begin : result_side
    int unsigned stall;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        book.check_result(out_data);
        results_seen++;
        if (results_seen % 50 == 0) receiver_quiet = ($urandom_range(0, 2) == 0);
        stall = receiver_quiet ? 0 : $urandom_range(0, 11);
        // long hold-off so the block backs up and stalls its input
        if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
        if (stall != 0) begin
          @(negedge clk) out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned failures;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    send_item(reg_item(OP_READ, REG_JOY_A, 8'h00));
    send_item(reg_item(OP_READ, REG_AUX, 8'h00));
    send_item(tick_item(16'h0000, 1'b0, 1'b0, 5'h00, 1'b0));
    send_item(reg_item(OP_WRITE, REG_KEY_DIR, 8'hFF));
    send_item(reg_item(OP_WRITE, REG_KEY_B, 8'h00));
    send_item(tick_item(16'h1234, 1'b0, 1'b0, 5'h00, 1'b0));
    send_item(tick_item(16'h0000, 1'b0, 1'b0, 5'h00, 1'b0));
    send_item(reg_item(OP_WRITE, REG_KEY_B, COL_SHIFT));
    send_item(tick_item({COL_SHIFT, 8'hFE}, 1'b1, 1'b0, 5'h00, 1'b0));
    send_item(tick_item(16'h0000, 1'b1, 1'b0, 5'h00, 1'b0));
    send_item(reg_item(OP_WRITE, REG_KEY_B, COL_CBM));
    send_item(tick_item({COL_CBM, 8'h7F}, 1'b0, 1'b1, 5'h00, 1'b0));
    send_item(tick_item(16'hFFFF, 1'b0, 1'b1, 5'h00, 1'b0));
    send_item(tick_item({COL_CBM, 8'h00}, 1'b0, 1'b0, 5'h00, 1'b0));
    send_item(tick_item(16'h5F12, 1'b0, 1'b0, 5'h1F, 1'b0));
    send_item(reg_item(OP_WRITE, REG_T1C_LO, 8'h02));
    send_item(reg_item(OP_WRITE, REG_T1L_LO, 8'h03));
    send_item(reg_item(OP_WRITE, REG_AUX, AUX_T1_RELOAD));
    send_item(reg_item(OP_WRITE, REG_ENABLE, 8'hFF));
    send_item(reg_item(OP_WRITE, REG_T2C_LO, 8'h01));
    send_item(reg_item(OP_WRITE, REG_T2L_LO, 8'h05));
    send_item(reg_item(OP_WRITE, REG_T2_ARMED, 8'hFF));
    send_item(tick_item(16'h0000, 1'b0, 1'b0, 5'h00, 1'b0));
    send_item(tick_item(16'h0000, 1'b0, 1'b0, 5'h00, 1'b1));
    send_item(tick_item(16'h0000, 1'b0, 1'b0, 5'h00, 1'b1));
    send_item('1);
    send_item(reg_item(OP_READ, REG_FLAGS, 8'h00));

    counted_ops = 0;
    while (counted_ops < RANDOM_OPS) begin
      sender_quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send_item(noise_item());
      end else begin
        repeat ($urandom_range(1, 6)) send_item(setup_write());
        repeat ($urandom_range(4, 30)) begin
          case ($urandom_range(0, 9))
            7, 8: send_item(reg_item(OP_READ, 4'($urandom), 8'($urandom)));
            9: send_item(setup_write());
            default: send_item(random_tick());
          endcase
        end
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    failures = book.mismatches + book.pending_results.size();
    if (failures == 0)
      $display("via_timer_keyboard_port_model verification clean");
    else
      $display("via_timer_keyboard_port_model verification failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/vtkp_pkg.sv
hw/rtl/via_timer_keyboard_port_model.sv
bench/vtkp_tb_pkg.sv
bench/via_timer_keyboard_port_model_tb.sv
